// ===== sv/ordered_list_engine_core_macros.svh =====
// Assertion macros shared by the ordered list engine RTL.
`ifndef ORDERED_LIST_ENGINE_CORE_MACROS_SVH
`define ORDERED_LIST_ENGINE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OLE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered list engine assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define OLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered list engine assertion failed");

`endif

// ===== sv/olist_pkg.sv =====
// Package with the request codes, status codes and result type of the ordered list engine.
`default_nettype none

package olist_pkg;

   localparam int TYPE_W  = 3;
   localparam int POS_W   = 6;
   localparam int VAL_W   = 32;
   localparam int STAT_W  = 2;
   localparam int FIDX_W  = 6;
   localparam int COUNT_W = 7;

   // Request kinds.
   localparam logic [TYPE_W-1:0] REQ_APPEND  = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_INSERT  = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_REM_VAL = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_REM_POS = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_READ    = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_SEARCH  = 3'd5;

   // Response status codes.
   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [VAL_W-1:0]   read_value;
      logic [FIDX_W-1:0]  found_index;
      logic [COUNT_W-1:0] entry_count;
   } olist_rsp_type;

endpackage

`default_nettype wire

// ===== sv/olist_mem.sv =====
// Single-port-write, single-port-read entry memory with a registered read.
`default_nettype none

module olist_mem
   import olist_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [VAL_W-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [VAL_W-1:0] rdata
);

   logic [VAL_W-1:0] store_ff [DEPTH];
   logic [VAL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= store_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== sv/olist_ctrl.sv =====
// Sequencer that sweeps the entry memory to shift, scan and update the list.
`default_nettype none

module olist_ctrl
   import olist_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int CW    = 7
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [TYPE_W-1:0] req_type,
   input  wire logic [POS_W-1:0]  req_position,
   input  wire logic [VAL_W-1:0]  req_value,
   output logic                   busy,
   input  wire logic              out_free,
   output logic                   push,
   output olist_rsp_type          rsp,
   output logic                   mem_we,
   output logic      [AW-1:0]     mem_waddr,
   output logic      [VAL_W-1:0]  mem_wdata,
   output logic                   mem_re,
   output logic      [AW-1:0]     mem_raddr,
   input  wire logic [VAL_W-1:0]  mem_rdata
);

   localparam int PW = (CW > POS_W) ? CW : POS_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DN   = 3'd1;
   localparam logic [2:0] ST_UP   = 3'd2;
   localparam logic [2:0] ST_PUT  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              issue_ff, issue_in;
   logic              rvld_ff, rvld_in;
   logic              hit_ff, hit_in;
   logic [TYPE_W-1:0] kind_ff, kind_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [AW-1:0]     raddr_d_ff, raddr_d_in;
   logic [AW-1:0]     put_addr_ff, put_addr_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [VAL_W-1:0]  rd_ff, rd_in;
   logic [FIDX_W-1:0] fidx_ff, fidx_in;

   logic          pos_ok;
   logic          is_full;
   logic          pos_kind;
   logic          match;
   logic          ends_now;
   logic [CW-1:0] last_idx;

   assign last_idx = count_ff - CW'(1);
   assign pos_ok   = PW'(req_position) < PW'(count_ff);
   assign is_full  = count_ff == CW'(DEPTH);
   assign pos_kind = kind_ff inside {REQ_REM_POS, REQ_READ};
   // The first returned entry always matches a positional request.
   assign match    = pos_kind || (mem_rdata == val_ff);
   assign ends_now = !hit_ff && match && (kind_ff inside {REQ_READ, REQ_SEARCH});

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      issue_in    = issue_ff;
      hit_in      = hit_ff;
      kind_in     = kind_ff;
      val_in      = val_ff;
      addr_in     = addr_ff;
      put_addr_in = put_addr_ff;
      status_in   = status_ff;
      rd_in       = rd_ff;
      fidx_in     = fidx_ff;
      rvld_in     = issue_ff;
      raddr_d_in  = addr_ff;
      mem_re      = issue_ff;
      mem_raddr   = addr_ff;
      mem_we      = 1'b0;
      mem_waddr   = put_addr_ff;
      mem_wdata   = mem_rdata;

      // Read address walk: upward for scans and removals, downward for inserts.
      if (issue_ff) begin
         if (state_ff == ST_DN) begin
            if (CW'(addr_ff) == last_idx) begin
               issue_in = 1'b0;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end else begin
            if (addr_ff == put_addr_ff) begin
               issue_in = 1'b0;
            end else begin
               addr_in = addr_ff - AW'(1);
            end
         end
      end

      case (state_ff)
         ST_IDLE: begin
            issue_in = 1'b0;
            if (req_valid) begin
               kind_in     = req_type;
               val_in      = req_value;
               rd_in       = '0;
               fidx_in     = '0;
               hit_in      = 1'b0;
               status_in   = STAT_MISS;
               put_addr_in = AW'(req_position);
               case (req_type)
                  REQ_APPEND, REQ_INSERT: begin
                     if (is_full) begin
                        status_in = STAT_FULL;
                        state_in  = ST_DONE;
                     end else if (req_type == REQ_APPEND || !pos_ok) begin
                        put_addr_in = AW'(count_ff);
                        state_in    = ST_PUT;
                     end else begin
                        addr_in  = AW'(last_idx);
                        issue_in = 1'b1;
                        state_in = ST_UP;
                     end
                  end
                  REQ_REM_VAL, REQ_SEARCH: begin
                     if (count_ff == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        addr_in  = '0;
                        issue_in = 1'b1;
                        state_in = ST_DN;
                     end
                  end
                  REQ_REM_POS, REQ_READ: begin
                     if (!pos_ok) begin
                        state_in = ST_DONE;
                     end else begin
                        addr_in  = AW'(req_position);
                        issue_in = 1'b1;
                        state_in = ST_DN;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_DN: begin
            if (rvld_ff) begin
               if (hit_ff) begin
                  // Close the gap: each later entry moves down by one.
                  mem_we    = 1'b1;
                  mem_waddr = raddr_d_ff - AW'(1);
               end else if (match) begin
                  hit_in = 1'b1;
                  if (pos_kind) begin
                     rd_in = mem_rdata;
                  end
                  if (kind_ff == REQ_SEARCH) begin
                     fidx_in = FIDX_W'(raddr_d_ff);
                  end
               end
               if (ends_now) begin
                  status_in = STAT_OK;
                  issue_in  = 1'b0;
                  state_in  = ST_DONE;
               end else if (CW'(raddr_d_ff) == last_idx) begin
                  if (hit_ff || match) begin
                     status_in = STAT_OK;
                     count_in  = count_ff - CW'(1);
                  end
                  state_in = ST_DONE;
               end
            end
         end
         ST_UP: begin
            if (rvld_ff) begin
               // Open the gap: each entry from the position upward moves up by one.
               mem_we    = 1'b1;
               mem_waddr = raddr_d_ff + AW'(1);
               if (raddr_d_ff == put_addr_ff) begin
                  state_in = ST_PUT;
               end
            end
         end
         ST_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = put_addr_ff;
            mem_wdata = val_ff;
            count_in  = count_ff + CW'(1);
            status_in = STAT_OK;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            issue_in = 1'b0;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         issue_ff <= 1'b0;
         rvld_ff  <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         issue_ff <= issue_in;
         rvld_ff  <= rvld_in;
         hit_ff   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      val_ff      <= val_in;
      addr_ff     <= addr_in;
      raddr_d_ff  <= raddr_d_in;
      put_addr_ff <= put_addr_in;
      status_ff   <= status_in;
      rd_ff       <= rd_in;
      fidx_ff     <= fidx_in;
   end

   assign busy = state_ff != ST_IDLE;
   assign push = (state_ff == ST_DONE) && out_free;

   assign rsp.status      = status_ff;
   assign rsp.read_value  = rd_ff;
   assign rsp.found_index = fidx_ff;
   assign rsp.entry_count = COUNT_W'(count_ff);

endmodule

`default_nettype wire

// ===== sv/ordered_list_engine_core.sv =====
// Top level of the ordered list engine: sequencer, entry memory and response register.
// The request channel (req_valid, req_stall, req_type, req_position, req_value) carries
// one list operation per transaction: append, insert at a position, remove a value,
// remove at a position, read at a position, or search for a value.
// The response channel (rsp_valid, rsp_stall, rsp_*) returns exactly one transaction per
// request, in order, with a status, a read value, a found index and the entry count.
// The block works on one request at a time; req_stall stays high from acceptance until
// the response moves into the output register, and the next request is taken only after
// that. A full list, an out-of-range position, an empty list or an unused code goes
// straight to the response; an append or an insert at or past the end writes the value
// at the end of the list in the put step. The other requests sweep the memory one entry
// per cycle: an insert reads from the last entry down to its position, moves each of
// those entries up by one and then writes the value in the put step; a removal moves
// each entry after the removed one down by one; a read or a search stops at the first
// match, while a value removal or a missed search reads every entry.
// While rsp_stall holds a response in the output register, the next request is still
// accepted and finished; its response then waits in the sequencer, which keeps the
// request side stalled until the register frees up.
// Synchronous reset empties the list and drops any pending response. The entry
// memory itself is not cleared, because entries at or above the count are never read.

`default_nettype none

`include "ordered_list_engine_core_macros.svh"

module ordered_list_engine_core
   import olist_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [TYPE_W-1:0]  req_type,
   input  wire logic [POS_W-1:0]   req_position,
   input  wire logic [VAL_W-1:0]   req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [STAT_W-1:0]  rsp_status,
   output logic      [VAL_W-1:0]   rsp_read_value,
   output logic      [FIDX_W-1:0]  rsp_found_index,
   output logic      [COUNT_W-1:0] rsp_entry_count
);

   // Address width covers every entry; count width also covers a full list.
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic             busy;
   logic             out_free;
   logic             push;
   olist_rsp_type    ctrl_rsp;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [VAL_W-1:0] mem_wdata;
   logic             mem_re;
   logic [AW-1:0]    mem_raddr;
   logic [VAL_W-1:0] mem_rdata;

   logic          rsp_valid_ff, rsp_valid_in;
   olist_rsp_type rsp_ff;

   logic          full_rsp;
   logic          fail_rsp;

   olist_ctrl #(
      .DEPTH(DEPTH),
      .AW   (AW),
      .CW   (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_type    (req_type),
      .req_position(req_position),
      .req_value   (req_value),
      .busy        (busy),
      .out_free    (out_free),
      .push        (push),
      .rsp         (ctrl_rsp),
      .mem_we      (mem_we),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .mem_re      (mem_re),
      .mem_raddr   (mem_raddr),
      .mem_rdata   (mem_rdata)
   );

   olist_mem #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_mem (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .re   (mem_re),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   // The sequencer takes a new request only while it is idle.
   assign req_stall = busy;

   // The output register can take a response when empty or when its content leaves now.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_ff <= ctrl_rsp;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_read_value  = rsp_ff.read_value;
   assign rsp_found_index = rsp_ff.found_index;
   assign rsp_entry_count = rsp_ff.entry_count;

   assign full_rsp = rsp_valid_ff && (rsp_ff.status == STAT_FULL);
   assign fail_rsp = rsp_valid_ff && (rsp_ff.status != STAT_OK);

   // A full status is only reported when the list holds DEPTH entries.
   `OLE_ASSERT_NOW(a_full_count, clock, reset, full_rsp, rsp_entry_count == COUNT_W'(DEPTH))
   // Failed requests return zero in both data fields.
   `OLE_ASSERT_NOW(a_fail_zero, clock, reset, fail_rsp, rsp_read_value == '0 && rsp_found_index == '0)
   // Once a request is taken, the sequencer is busy with it in the next cycle.
   `OLE_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall)

endmodule

`default_nettype wire
